// ===== rtl/core/ubx_pkg.sv =====
// ----------------------------------------------------------------------------
// UBX frame receiver package
// Shared result type, event codes, register indexes and protocol constants.
// ----------------------------------------------------------------------------
package ubx_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_CLASS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID    = 2'd1;

  localparam logic [7:0] EXPECTED_CLASS_RST = 8'd6;
  localparam logic [7:0] EXPECTED_ID_RST    = 8'd138;

  localparam logic [7:0] SYNC_A    = 8'hB5;
  localparam logic [7:0] SYNC_B    = 8'h62;
  localparam logic [7:0] CLS_NAV   = 8'h01;
  localparam logic [7:0] ID_POSLLH = 8'h02;
  localparam logic [7:0] CLS_ACK   = 8'h05;
  localparam logic [7:0] ID_ACK    = 8'h01;
  localparam logic [7:0] ID_NAK    = 8'h00;

  localparam logic [15:0] POS_LEN = 16'd28;
  localparam logic [15:0] ACK_LEN = 16'd2;

  localparam logic [1:0] EV_ACK   = 2'd0;
  localparam logic [1:0] EV_NAK   = 2'd1;
  localparam logic [1:0] EV_POS   = 2'd2;
  localparam logic [1:0] EV_OTHER = 2'd3;

  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [31:0] longitude;
    logic signed [31:0] latitude;
    logic signed [31:0] altitude_mm;
  } ubx_result_t;

endpackage

// ===== rtl/core/ubx_parser.sv =====
// ----------------------------------------------------------------------------
// UBX frame parser
// Byte-wise frame tracker; captures ACK and POSLLH payload fields and
// decides the frame event on the second checksum byte.
// ----------------------------------------------------------------------------
module ubx_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_vld,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         expected_class,
  input  logic [7:0]         expected_id,
  output logic               res_vld,
  output ubx_pkg::ubx_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_CLASS,
    PH_ID,
    PH_LENL,
    PH_LENH,
    PH_PAYLOAD,
    PH_CHECK
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [7:0]  ack_cls_r, ack_cls_nxt;
  logic [7:0]  ack_id_r, ack_id_nxt;
  logic [31:0] lon_r, lon_nxt;
  logic [31:0] lat_r, lat_nxt;
  logic [31:0] alt_r, alt_nxt;

  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic        is_posllh;
  logic [1:0]  ev;

  assign cnt_inc   = cnt_r + 16'd1;
  assign len_full  = {rx_byte, len_r[7:0]};
  assign is_posllh = (class_r == ubx_pkg::CLS_NAV) && (id_r == ubx_pkg::ID_POSLLH);

  always_comb begin
    if ((class_r == ubx_pkg::CLS_ACK) && (len_r == ubx_pkg::ACK_LEN) &&
        ((id_r == ubx_pkg::ID_ACK) || (id_r == ubx_pkg::ID_NAK)) &&
        (ack_cls_r == expected_class) && (ack_id_r == expected_id)) begin
      ev = (id_r == ubx_pkg::ID_ACK) ? ubx_pkg::EV_ACK : ubx_pkg::EV_NAK;
    end else if (is_posllh && (len_r == ubx_pkg::POS_LEN)) begin
      ev = ubx_pkg::EV_POS;
    end else begin
      ev = ubx_pkg::EV_OTHER;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    class_nxt   = class_r;
    id_nxt      = id_r;
    len_nxt     = len_r;
    cnt_nxt     = cnt_r;
    ack_cls_nxt = ack_cls_r;
    ack_id_nxt  = ack_id_r;
    lon_nxt     = lon_r;
    lat_nxt     = lat_r;
    alt_nxt     = alt_r;
    res_vld     = 1'b0;
    res.event_res   = ev;
    res.longitude   = (ev == ubx_pkg::EV_POS) ? lon_r : 32'd0;
    res.latitude    = (ev == ubx_pkg::EV_POS) ? lat_r : 32'd0;
    res.altitude_mm = (ev == ubx_pkg::EV_POS) ? alt_r : 32'd0;
    if (byte_vld) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == ubx_pkg::SYNC_A) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (rx_byte == ubx_pkg::SYNC_B) phase_nxt = PH_CLASS;
          else if (rx_byte != ubx_pkg::SYNC_A) phase_nxt = PH_IDLE;
        end
        PH_CLASS: begin
          class_nxt = rx_byte;
          phase_nxt = PH_ID;
        end
        PH_ID: begin
          id_nxt    = rx_byte;
          phase_nxt = PH_LENL;
        end
        PH_LENL: begin
          len_nxt   = {8'd0, rx_byte};
          phase_nxt = PH_LENH;
        end
        PH_LENH: begin
          len_nxt   = len_full;
          cnt_nxt   = 16'd0;
          phase_nxt = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (class_r == ubx_pkg::CLS_ACK) begin
            if (cnt_r == 16'd0) ack_cls_nxt = rx_byte;
            else if (cnt_r == 16'd1) ack_id_nxt = rx_byte;
          end else if (is_posllh) begin
            if (cnt_r[15:2] == 14'd1) lon_nxt[8*cnt_r[1:0] +: 8] = rx_byte;
            else if (cnt_r[15:2] == 14'd2) lat_nxt[8*cnt_r[1:0] +: 8] = rx_byte;
            else if (cnt_r[15:2] == 14'd4) alt_nxt[8*cnt_r[1:0] +: 8] = rx_byte;
          end
          if (cnt_inc == len_r) begin
            cnt_nxt   = 16'd0;
            phase_nxt = PH_CHECK;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        PH_CHECK: begin
          if (cnt_r == 16'd0) begin
            cnt_nxt = 16'd1;
          end else begin
            cnt_nxt   = 16'd0;
            phase_nxt = PH_IDLE;
            res_vld   = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      class_r   <= 8'd0;
      id_r      <= 8'd0;
      len_r     <= 16'd0;
      cnt_r     <= 16'd0;
      ack_cls_r <= 8'd0;
      ack_id_r  <= 8'd0;
      lon_r     <= 32'd0;
      lat_r     <= 32'd0;
      alt_r     <= 32'd0;
    end else begin
      phase_r   <= phase_nxt;
      class_r   <= class_nxt;
      id_r      <= id_nxt;
      len_r     <= len_nxt;
      cnt_r     <= cnt_nxt;
      ack_cls_r <= ack_cls_nxt;
      ack_id_r  <= ack_id_nxt;
      lon_r     <= lon_nxt;
      lat_r     <= lat_nxt;
      alt_r     <= alt_nxt;
    end
  end

endmodule

// ===== rtl/core/ubx_out_buf.sv =====
// ----------------------------------------------------------------------------
// UBX result buffer
// Output register with a skid entry; parts the byte side from the result side.
// ----------------------------------------------------------------------------
module ubx_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ubx_pkg::ubx_result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ubx_pkg::ubx_result_t out_data
);

  logic                 main_vld_r, main_vld_nxt;
  logic                 skid_vld_r, skid_vld_nxt;
  ubx_pkg::ubx_result_t main_r, main_nxt;
  ubx_pkg::ubx_result_t skid_r, skid_nxt;
  logic                 pop;

  assign pop       = main_vld_r && !out_stall;
  assign full      = skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      if (pop) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end
    end else if (main_vld_r) begin
      if (push && pop) begin
        main_nxt = push_data;
      end else if (push) begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end else if (pop) begin
        main_vld_nxt = 1'b0;
      end
    end else if (push) begin
      main_nxt     = push_data;
      main_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== rtl/core/ubx_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// UBX frame receiver
// Takes one serial byte a beat, follows UBX frames and reports one event per
// complete frame: matched ACK, matched NAK, NAV-POSLLH position, or other.
// ----------------------------------------------------------------------------
// Accepts one byte beat every clock cycle while in_stall is low. The frame
// event is decided in the cycle the second checksum byte is accepted and is
// registered in the output register, or in the skid entry while it is busy;
// in_stall rises only while both entries hold untaken results. The checksum
// is not verified. Position fields are raw: longitude and latitude in 1e-7
// degrees, altitude in millimetres, and zero for all other events.
module ubx_frame_receiver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           in_rx_byte,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_event_res,
  output logic signed [31:0]                   out_longitude,
  output logic signed [31:0]                   out_latitude,
  output logic signed [31:0]                   out_altitude_mm,
  input  logic                                 cfg_we,
  input  logic [ubx_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ubx_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [7:0]           exp_cls_r;
  logic [7:0]           exp_id_r;
  logic                 byte_vld;
  logic                 res_vld;
  logic                 buf_full;
  ubx_pkg::ubx_result_t res;
  ubx_pkg::ubx_result_t out_data;

  assign in_stall    = buf_full;
  assign byte_vld    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_cls_r <= ubx_pkg::EXPECTED_CLASS_RST;
      exp_id_r  <= ubx_pkg::EXPECTED_ID_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ubx_pkg::CFG_EXPECTED_CLASS: exp_cls_r <= cfg_data;
        ubx_pkg::CFG_EXPECTED_ID:    exp_id_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  ubx_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_vld       (byte_vld),
    .rx_byte        (in_rx_byte),
    .expected_class (exp_cls_r),
    .expected_id    (exp_id_r),
    .res_vld        (res_vld),
    .res            (res)
  );

  ubx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_vld),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_event_res   = out_data.event_res;
  assign out_longitude   = out_data.longitude;
  assign out_latitude    = out_data.latitude;
  assign out_altitude_mm = out_data.altitude_mm;

endmodule

// ===== tb/sv/ubx_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UBX frame event checker
// Watches the byte, event and register ports of the frame receiver. It keeps
// its own copy of the frame parser and the awaited command, queues one event
// for each frame completed, and compares every event beat with the oldest
// queued one, field by field.
// ----------------------------------------------------------------------------
module ubx_frame_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [1:0]                     out_event_res,
  input  logic signed [31:0]             out_longitude,
  input  logic signed [31:0]             out_latitude,
  input  logic signed [31:0]             out_altitude_mm,
  input  logic                           cfg_we,
  input  logic [ubx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ubx_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  typedef enum logic [2:0] {
    ST_HUNT, ST_SYNC_B, ST_CLASS, ST_ID, ST_LEN_LO, ST_LEN_HI, ST_PAYLOAD, ST_CKSUM
  } parse_state_t;

  parse_state_t         parse_state;
  logic [7:0]           exp_class, exp_id;
  logic [7:0]           frm_class, frm_id;
  logic [15:0]          frm_len, seen;
  logic [7:0]           ack_cls, ack_id;
  logic [31:0]          lon_w, lat_w, alt_w;
  ubx_pkg::ubx_result_t frame_events[$];
  int                   errs = 0;

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, output bit fired,
                             output ubx_pkg::ubx_result_t res);
    fired = 1'b0;
    res = '0;
    case (parse_state)
      ST_HUNT: if (b == ubx_pkg::SYNC_A) parse_state = ST_SYNC_B;
      ST_SYNC_B: begin
        if (b == ubx_pkg::SYNC_B) parse_state = ST_CLASS;
        else if (b != ubx_pkg::SYNC_A) parse_state = ST_HUNT;
      end
      ST_CLASS: begin
        frm_class = b;
        parse_state = ST_ID;
      end
      ST_ID: begin
        frm_id = b;
        parse_state = ST_LEN_LO;
      end
      ST_LEN_LO: begin
        frm_len = {8'h00, b};
        parse_state = ST_LEN_HI;
      end
      ST_LEN_HI: begin
        frm_len = {b, frm_len[7:0]};
        seen = '0;
        parse_state = (frm_len == 16'd0) ? ST_CKSUM : ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        if (frm_class == ubx_pkg::CLS_ACK) begin
          if (seen == 16'd0) ack_cls = b;
          else if (seen == 16'd1) ack_id = b;
        end else if (frm_class == ubx_pkg::CLS_NAV && frm_id == ubx_pkg::ID_POSLLH) begin
          if (seen >= 16'd4 && seen < 16'd8) lon_w[8*seen[1:0] +: 8] = b;
          else if (seen >= 16'd8 && seen < 16'd12) lat_w[8*seen[1:0] +: 8] = b;
          else if (seen >= 16'd16 && seen < 16'd20) alt_w[8*seen[1:0] +: 8] = b;
        end
        seen = seen + 16'd1;
        if (seen == frm_len) begin
          seen = '0;
          parse_state = ST_CKSUM;
        end
      end
      default: begin
        if (seen == 16'd0) begin
          seen = 16'd1;
        end else begin
          seen = '0;
          parse_state = ST_HUNT;
          fired = 1'b1;
          if (frm_class == ubx_pkg::CLS_ACK && frm_len == ubx_pkg::ACK_LEN &&
              (frm_id == ubx_pkg::ID_ACK || frm_id == ubx_pkg::ID_NAK) &&
              ack_cls == exp_class && ack_id == exp_id) begin
            res.event_res = (frm_id == ubx_pkg::ID_ACK) ? ubx_pkg::EV_ACK : ubx_pkg::EV_NAK;
          end else if (frm_class == ubx_pkg::CLS_NAV && frm_id == ubx_pkg::ID_POSLLH &&
                       frm_len == ubx_pkg::POS_LEN) begin
            res.event_res   = ubx_pkg::EV_POS;
            res.longitude   = lon_w;
            res.latitude    = lat_w;
            res.altitude_mm = alt_w;
          end else begin
            res.event_res = ubx_pkg::EV_OTHER;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    bit                   fired;
    ubx_pkg::ubx_result_t res;
    ubx_pkg::ubx_result_t want;
    if (!rst_n) begin
      parse_state = ST_HUNT;
      exp_class   = ubx_pkg::EXPECTED_CLASS_RST;
      exp_id      = ubx_pkg::EXPECTED_ID_RST;
      frm_class   = '0;
      frm_id      = '0;
      frm_len     = '0;
      seen        = '0;
      ack_cls     = '0;
      ack_id      = '0;
      lon_w       = '0;
      lat_w       = '0;
      alt_w       = '0;
      frame_events.delete();
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(in_rx_byte, fired, res);
        if (fired) frame_events.push_back(res);
      end
      if (cfg_we) begin
        if (cfg_index == ubx_pkg::CFG_EXPECTED_CLASS) exp_class = cfg_data;
        else if (cfg_index == ubx_pkg::CFG_EXPECTED_ID) exp_id = cfg_data;
      end
      if (out_valid && !out_stall) begin
        if (frame_events.size() == 0) begin
          $error("event beat with none awaited: event_res %0d", out_event_res);
          errs++;
        end else begin
          want = frame_events.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(out_event_res));
          check_field("longitude", want.longitude, out_longitude);
          check_field("latitude", want.latitude, out_latitude);
          check_field("altitude_mm", want.altitude_mm, out_altitude_mm);
        end
      end
    end
    outstanding <= frame_events.size();
    mismatches  <= errs;
  end

endmodule

// ===== tb/sv/tb_ubx_frame_receiver.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// UBX frame receiver testbench
// Feeds sync noise, acknowledge, position and other UBX frames byte by byte
// with random gaps and event stalls, changes the awaited command between
// phases, and leaves the checking to the frame event checker.
// ----------------------------------------------------------------------------
module tb_ubx_frame_receiver;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic [7:0]                     in_rx_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic [1:0]                     out_event_res;
  logic signed [31:0]             out_longitude;
  logic signed [31:0]             out_latitude;
  logic signed [31:0]             out_altitude_mm;
  logic                           cfg_we;
  logic [ubx_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [ubx_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             mismatches;
  int                             outstanding;

  logic [7:0] want_class = ubx_pkg::EXPECTED_CLASS_RST;
  logic [7:0] want_id    = ubx_pkg::EXPECTED_ID_RST;
  bit         send_burst = 1'b0;
  bit         sink_burst = 1'b0;
  int         sent_bytes = 0;

  always #5 clk = ~clk;

  ubx_frame_receiver DUT (.*);

  ubx_frame_checker frame_check (.*);

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent_bytes++;
  endtask

  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input logic [7:0] body[$]);
    logic [15:0] len;
    len = 16'(body.size());
    send_byte(ubx_pkg::SYNC_A);
    send_byte(ubx_pkg::SYNC_B);
    send_byte(cls);
    send_byte(id);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    foreach (body[k]) send_byte(body[k]);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [7:0] cls, input logic [7:0] id);
    cfg_we    <= 1'b1;
    cfg_index <= ubx_pkg::CFG_EXPECTED_CLASS;
    cfg_data  <= cls;
    @(posedge clk);
    cfg_index <= ubx_pkg::CFG_EXPECTED_ID;
    cfg_data  <= id;
    @(posedge clk);
    cfg_we <= 1'b0;
    want_class = cls;
    want_id    = id;
  endtask

  function automatic void random_body(ref logic [7:0] body[$], input int n);
    body.delete();
    repeat (n) body.push_back(8'($urandom));
  endfunction

  function automatic void set_word(ref logic [7:0] body[$], input int at,
                                   input logic [31:0] w);
    for (int k = 0; k < 4; k++) body[at+k] = w[8*k +: 8];
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_item();
    logic [7:0] body[$];
    logic [7:0] id;
    int         sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      random_body(body, int'(ubx_pkg::POS_LEN));
      set_word(body, 4, pick_word());
      set_word(body, 8, pick_word());
      set_word(body, 16, pick_word());
      send_frame(ubx_pkg::CLS_NAV, ubx_pkg::ID_POSLLH, body);
    end else if (sel < 55) begin
      if ($urandom_range(0, 3) == 0) id = 8'($urandom);
      else id = $urandom_range(0, 1) ? ubx_pkg::ID_ACK : ubx_pkg::ID_NAK;
      random_body(body, ($urandom_range(0, 4) != 0) ? int'(ubx_pkg::ACK_LEN) :
                                                      int'($urandom_range(0, 4)));
      if (body.size() >= 2 && $urandom_range(0, 9) < 7) begin
        body[0] = want_class;
        body[1] = want_id;
        if ($urandom_range(0, 7) == 0) body[$urandom_range(0, 1)] ^= 8'h01 << $urandom_range(0, 7);
      end
      send_frame(ubx_pkg::CLS_ACK, id, body);
    end else if (sel < 65) begin
      random_body(body, $urandom_range(0, 40));
      send_frame(ubx_pkg::CLS_NAV, ubx_pkg::ID_POSLLH, body);
    end else if (sel < 85) begin
      random_body(body, $urandom_range(0, 8));
      send_frame(8'($urandom), 8'($urandom), body);
    end else begin
      repeat ($urandom_range(1, 6))
        send_byte(($urandom_range(0, 2) == 0) ? ubx_pkg::SYNC_A : 8'($urandom));
    end
  endtask

  initial begin
    int hold;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = sink_burst ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [7:0] body[$];
    int         phase_no;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ubx_pkg::SYNC_A);
    send_byte(8'h00);
    send_byte(ubx_pkg::SYNC_A);
    send_byte(ubx_pkg::SYNC_A);
    body = {ubx_pkg::EXPECTED_CLASS_RST, ubx_pkg::EXPECTED_ID_RST};
    send_frame(ubx_pkg::CLS_ACK, ubx_pkg::ID_ACK, body);
    send_frame(ubx_pkg::CLS_ACK, ubx_pkg::ID_NAK, body);
    body.delete();
    send_frame(8'hFF, 8'hFF, body);
    random_body(body, int'(ubx_pkg::POS_LEN));
    set_word(body, 4, 32'h8000_0000);
    set_word(body, 8, 32'h7FFF_FFFF);
    set_word(body, 16, 32'hFFFF_FFFF);
    send_frame(ubx_pkg::CLS_NAV, ubx_pkg::ID_POSLLH, body);
    random_body(body, 27);
    send_frame(ubx_pkg::CLS_NAV, ubx_pkg::ID_POSLLH, body);
    body = {8'h12, 8'h34};
    send_frame(ubx_pkg::CLS_ACK, ubx_pkg::ID_ACK, body);

    // change the awaited command halfway through an acknowledge
    send_byte(ubx_pkg::SYNC_A);
    send_byte(ubx_pkg::SYNC_B);
    send_byte(ubx_pkg::CLS_ACK);
    send_byte(ubx_pkg::ID_ACK);
    send_byte(ubx_pkg::ACK_LEN[7:0]);
    send_byte(ubx_pkg::ACK_LEN[15:8]);
    settle();
    reconfigure(8'hFF, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'($urandom));
    send_byte(8'($urandom));

    settle();
    send_burst = 1'b1;
    random_body(body, 300);
    send_frame(8'($urandom), 8'($urandom), body);
    send_burst = 1'b0;

    phase_no = 0;
    while (sent_bytes < 950) begin
      settle();
      case (phase_no % 4)
        0: reconfigure(8'h00, 8'h00);
        1: reconfigure(8'hFF, 8'hFF);
        default: reconfigure(8'($urandom), 8'($urandom));
      endcase
      send_burst = ($urandom_range(0, 3) == 0);
      sink_burst = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(6, 14)) if (sent_bytes < 950) random_item();
      phase_no++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 20000 && outstanding != 0; w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (outstanding != 0) $error("%0d frame events never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
